/* design/sllm_pkg.sv */
// ----------------------------------------------------------------------------
// sllm_pkg
// Shared types and codes for the slot linked list manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sllm_pkg;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        CMD_ADD_HEAD    = 4'd0,
        CMD_ADD_TAIL    = 4'd1,
        CMD_ADD_ORDERED = 4'd2,
        CMD_ADD_AFTER   = 4'd3,
        CMD_REMOVE_SLOT = 4'd4,
        CMD_REMOVE_HEAD = 4'd5,
        CMD_REMOVE_TAIL = 4'd6,
        CMD_SET         = 4'd7,
        CMD_READ        = 4'd8
    } cmd_t;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ_DONE,
        ST_SCAN,
        ST_ORDER_WALK,
        ST_INS_READ,
        ST_INS_WAIT,
        ST_INS_WRITE_NEW,
        ST_INS_WRITE_LINKS,
        ST_REMOVE,
        ST_EXT_START,
        ST_EXT_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } link_wr_t;

    typedef struct packed {
        logic        en;
        logic [7:0]  addr;
        logic [31:0] data;
    } value_wr_t;

endpackage

`default_nettype wire

/* design/sllm_mem.sv */
// ----------------------------------------------------------------------------
// sllm_mem
// Slot table: next links, prior links and values, one shared registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sllm_mem
    import sllm_pkg::*;
#(
    parameter int SLOT_COUNT = 256
)(
    input  wire logic        clk,
    input  wire logic [7:0]  rd_addr,
    input  wire link_wr_t    next_wr,
    input  wire link_wr_t    prior_wr,
    input  wire value_wr_t   value_wr,
    output logic      [31:0] rd_value,
    output logic      [7:0]  rd_next,
    output logic      [7:0]  rd_prior
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [7:0]  next_mem  [SLOT_COUNT];
    logic [7:0]  prior_mem [SLOT_COUNT];
    logic [31:0] value_mem [SLOT_COUNT];

    // Write each array at its own address
    always_ff @(posedge clk)
    begin
        if (next_wr.en)
        begin
            next_mem[next_wr.addr[AW-1:0]] <= next_wr.data;
        end
        if (prior_wr.en)
        begin
            prior_mem[prior_wr.addr[AW-1:0]] <= prior_wr.data;
        end
        if (value_wr.en)
        begin
            value_mem[value_wr.addr[AW-1:0]] <= value_wr.data;
        end
    end

    // Register the read beat
    always_ff @(posedge clk)
    begin
        rd_value <= value_mem[rd_addr[AW-1:0]];
        rd_next  <= next_mem[rd_addr[AW-1:0]];
        rd_prior <= prior_mem[rd_addr[AW-1:0]];
    end

endmodule

`default_nettype wire

/* design/slot_linked_list_manager.sv */
// ----------------------------------------------------------------------------
// slot_linked_list_manager
// Doubly linked list in a slot table with largest and smallest tracking.
// ----------------------------------------------------------------------------
// Flow: a rejected command or a read of slot 0 goes from decode to finish;
//   other reads pass a read-done state; an add scans for a free slot, an
//   ordered add then walks from the head, and every change walks the listed
//   slots to rebuild the extremes.
// Throughput: one command at a time; the table read port sets the walk rate.
// Reset: asynchronous, clears the used bits of all slots but the sentinel,
//   links of the sentinel, count and extremes at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module slot_linked_list_manager
    import sllm_pkg::*;
#(
    parameter int SLOT_COUNT = 256
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  cmd,
    input  wire logic [31:0] item_value,
    input  wire logic [31:0] order_key,
    input  wire logic [7:0]  slot_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [1:0]  status,
    output logic      [7:0]  result_slot,
    output logic      [31:0] read_value,
    output logic      [7:0]  read_next,
    output logic      [7:0]  read_prior,
    output logic      [7:0]  head_slot,
    output logic      [7:0]  last_slot,
    output logic      [7:0]  entry_count,
    output logic      [7:0]  largest_slot,
    output logic      [7:0]  smallest_slot
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [7:0] LAST_IDX = 8'(SLOT_COUNT - 1);
    localparam logic [8:0] SLOT_LIMIT = 9'(SLOT_COUNT);

    state_t state_reg, state_next;

    logic [SLOT_COUNT-1:0] used_reg, used_next;
    logic [7:0]  head_reg, head_next, last_reg, last_next;
    logic [7:0]  count_reg, count_next, max_reg, max_next, min_reg, min_next;
    logic [3:0]  cmd_reg;
    logic [31:0] val_reg, key_reg;
    logic [7:0]  idx_reg;
    logic [1:0]  stat_reg, stat_next;
    logic [7:0]  rslot_reg, rslot_next;
    logic [31:0] rval_reg, rval_next;
    logic [7:0]  rnext_reg, rnext_next, rprior_reg, rprior_next;
    logic [7:0]  cnt_reg, cnt_next, free_reg, free_next;
    logic [7:0]  tgt_reg, tgt_next, nn_reg, nn_next;
    logic [31:0] hi_reg, hi_next, lo_reg, lo_next;
    logic [7:0]  hi_id_reg, hi_id_next, lo_id_reg, lo_id_next;
    logic        out_valid_reg, load_out;

    logic [7:0]  rd_addr;
    logic [7:0]  rd_addr_q;
    link_wr_t    next_wr, prior_wr;
    value_wr_t   value_wr;
    logic [31:0] rd_value;
    logic [7:0]  rd_next, rd_prior;

    logic        idx_ok, rm_ok;
    logic [7:0]  rm_t;
    logic [31:0] cur_hi, cur_lo;
    logic [7:0]  cur_hi_id, cur_lo_id;

    sllm_mem #(.SLOT_COUNT(SLOT_COUNT)) u_mem (
        .clk      (clk),
        .rd_addr  (rd_addr),
        .next_wr  (next_wr),
        .prior_wr (prior_wr),
        .value_wr (value_wr),
        .rd_value (rd_value),
        .rd_next  (rd_next),
        .rd_prior (rd_prior)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    // Check slot targets against range and used bits
    always_comb
    begin
        idx_ok = ({1'b0, idx_reg} < SLOT_LIMIT) && used_reg[idx_reg[AW-1:0]];
        case (cmd_reg)
            CMD_REMOVE_HEAD: rm_t = head_reg;
            CMD_REMOVE_TAIL: rm_t = last_reg;
            default:         rm_t = idx_reg;
        endcase
        rm_ok = (rm_t != 8'd0) && ({1'b0, rm_t} < SLOT_LIMIT) && used_reg[rm_t[AW-1:0]];
    end

    // Fold the slot just read into the running extremes
    always_comb
    begin
        cur_hi    = hi_reg;
        cur_hi_id = hi_id_reg;
        cur_lo    = lo_reg;
        cur_lo_id = lo_id_reg;
        if (rd_value >= hi_reg)
        begin
            cur_hi    = rd_value;
            cur_hi_id = rd_addr_q;
        end
        if (rd_value <= lo_reg)
        begin
            cur_lo    = rd_value;
            cur_lo_id = rd_addr_q;
        end
    end

    // Remember which slot the read beat belongs to
    always_ff @(posedge clk)
    begin
        rd_addr_q <= rd_addr;
    end

    // Next state and datapath control
    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        head_next   = head_reg;
        last_next   = last_reg;
        count_next  = count_reg;
        max_next    = max_reg;
        min_next    = min_reg;
        stat_next   = stat_reg;
        rslot_next  = rslot_reg;
        rval_next   = rval_reg;
        rnext_next  = rnext_reg;
        rprior_next = rprior_reg;
        cnt_next    = cnt_reg;
        free_next   = free_reg;
        tgt_next    = tgt_reg;
        nn_next     = nn_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        hi_id_next  = hi_id_reg;
        lo_id_next  = lo_id_reg;
        rd_addr     = 8'd0;
        next_wr     = '0;
        prior_wr    = '0;
        value_wr    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    stat_next   = STAT_OK;
                    rslot_next  = 8'd0;
                    rval_next   = 32'd0;
                    rnext_next  = 8'd0;
                    rprior_next = 8'd0;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (cmd_reg)
                    CMD_ADD_HEAD, CMD_ADD_TAIL, CMD_ADD_ORDERED, CMD_ADD_AFTER:
                    begin
                        if ((cmd_reg == CMD_ADD_AFTER) && !idx_ok)
                        begin
                            stat_next  = STAT_INVALID;
                            rslot_next = idx_reg;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cnt_next   = 8'd1;
                            state_next = ST_SCAN;
                        end
                    end
                    CMD_REMOVE_SLOT, CMD_REMOVE_HEAD, CMD_REMOVE_TAIL:
                    begin
                        rslot_next = rm_t;
                        tgt_next   = rm_t;
                        rd_addr    = rm_t;
                        if (!rm_ok)
                        begin
                            stat_next  = STAT_INVALID;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_REMOVE;
                        end
                    end
                    CMD_SET:
                    begin
                        rslot_next = idx_reg;
                        if ((idx_reg == 8'd0) || !idx_ok)
                        begin
                            stat_next  = STAT_INVALID;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            value_wr   = '{en: 1'b1, addr: idx_reg, data: val_reg};
                            state_next = ST_EXT_START;
                        end
                    end
                    CMD_READ:
                    begin
                        rslot_next = idx_reg;
                        rd_addr    = idx_reg;
                        if (!idx_ok)
                        begin
                            stat_next  = STAT_INVALID;
                            state_next = ST_FINISH;
                        end
                        else if (idx_reg == 8'd0)
                        begin
                            rval_next   = ALL_ONES;
                            rnext_next  = head_reg;
                            rprior_next = last_reg;
                            state_next  = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_READ_DONE;
                        end
                    end
                    default:
                    begin
                        stat_next  = STAT_INVALID;
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_READ_DONE:
            begin
                rval_next   = rd_value;
                rnext_next  = rd_next;
                rprior_next = rd_prior;
                state_next  = ST_FINISH;
            end
            // Scan used bits one slot a cycle for the lowest free slot
            ST_SCAN:
            begin
                if (!used_reg[cnt_reg[AW-1:0]])
                begin
                    free_next  = cnt_reg;
                    state_next = ST_INS_READ;
                    case (cmd_reg)
                        CMD_ADD_HEAD: tgt_next = 8'd0;
                        CMD_ADD_TAIL: tgt_next = last_reg;
                        CMD_ADD_AFTER: tgt_next = idx_reg;
                        default:
                        begin
                            if (head_reg == 8'd0)
                            begin
                                tgt_next = last_reg;
                            end
                            else
                            begin
                                rd_addr    = head_reg;
                                state_next = ST_ORDER_WALK;
                            end
                        end
                    endcase
                end
                else if (cnt_reg == LAST_IDX)
                begin
                    stat_next  = STAT_FULL;
                    rslot_next = 8'd0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 8'd1;
                end
            end
            // Walk from the head until a value not below the key
            ST_ORDER_WALK:
            begin
                if (key_reg > rd_value)
                begin
                    if (rd_next == 8'd0)
                    begin
                        tgt_next   = last_reg;
                        state_next = ST_INS_READ;
                    end
                    else
                    begin
                        rd_addr = rd_next;
                    end
                end
                else
                begin
                    tgt_next   = rd_prior;
                    state_next = ST_INS_READ;
                end
            end
            ST_INS_READ:
            begin
                rd_addr    = tgt_reg;
                state_next = ST_INS_WAIT;
            end
            ST_INS_WAIT:
            begin
                nn_next    = (tgt_reg == 8'd0) ? head_reg : rd_next;
                state_next = ST_INS_WRITE_NEW;
            end
            ST_INS_WRITE_NEW:
            begin
                next_wr    = '{en: 1'b1, addr: free_reg, data: nn_reg};
                prior_wr   = '{en: 1'b1, addr: free_reg, data: tgt_reg};
                value_wr   = '{en: 1'b1, addr: free_reg, data: val_reg};
                used_next[free_reg[AW-1:0]] = 1'b1;
                count_next = count_reg + 8'd1;
                rslot_next = free_reg;
                state_next = ST_INS_WRITE_LINKS;
            end
            ST_INS_WRITE_LINKS:
            begin
                if (tgt_reg == 8'd0)
                begin
                    head_next = free_reg;
                end
                else
                begin
                    next_wr = '{en: 1'b1, addr: tgt_reg, data: free_reg};
                end
                if (nn_reg == 8'd0)
                begin
                    last_next = free_reg;
                end
                else
                begin
                    prior_wr = '{en: 1'b1, addr: nn_reg, data: free_reg};
                end
                state_next = ST_EXT_START;
            end
            // Bridge the neighbors of the removed slot
            ST_REMOVE:
            begin
                if (rd_prior == 8'd0)
                begin
                    head_next = rd_next;
                end
                else
                begin
                    next_wr = '{en: 1'b1, addr: rd_prior, data: rd_next};
                end
                if (rd_next == 8'd0)
                begin
                    last_next = rd_prior;
                end
                else
                begin
                    prior_wr = '{en: 1'b1, addr: rd_next, data: rd_prior};
                end
                used_next[tgt_reg[AW-1:0]] = 1'b0;
                count_next = count_reg - 8'd1;
                state_next = ST_EXT_START;
            end
            ST_EXT_START:
            begin
                hi_next    = 32'd0;
                lo_next    = ALL_ONES;
                hi_id_next = 8'd0;
                lo_id_next = 8'd0;
                if (head_reg == 8'd0)
                begin
                    max_next   = 8'd0;
                    min_next   = 8'd0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    rd_addr    = head_reg;
                    state_next = ST_EXT_WALK;
                end
            end
            // One listed slot a cycle; ties go to the later slot
            ST_EXT_WALK:
            begin
                hi_next    = cur_hi;
                lo_next    = cur_lo;
                hi_id_next = cur_hi_id;
                lo_id_next = cur_lo_id;
                if (rd_next == 8'd0)
                begin
                    max_next   = cur_hi_id;
                    min_next   = cur_lo_id;
                    state_next = ST_FINISH;
                end
                else
                begin
                    rd_addr = rd_next;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= {{(SLOT_COUNT-1){1'b0}}, 1'b1};
            head_reg      <= 8'd0;
            last_reg      <= 8'd0;
            count_reg     <= 8'd0;
            max_reg       <= 8'd0;
            min_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            head_reg  <= head_next;
            last_reg  <= last_next;
            count_reg <= count_next;
            max_reg   <= max_next;
            min_reg   <= min_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the command beat and working values
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd;
            val_reg <= item_value;
            key_reg <= order_key;
            idx_reg <= slot_index;
        end
        stat_reg   <= stat_next;
        rslot_reg  <= rslot_next;
        rval_reg   <= rval_next;
        rnext_reg  <= rnext_next;
        rprior_reg <= rprior_next;
        cnt_reg    <= cnt_next;
        free_reg   <= free_next;
        tgt_reg    <= tgt_next;
        nn_reg     <= nn_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        hi_id_reg  <= hi_id_next;
        lo_id_reg  <= lo_id_next;
    end

    // Load the result beat
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status        <= stat_reg;
            result_slot   <= rslot_reg;
            read_value    <= rval_reg;
            read_next     <= rnext_reg;
            read_prior    <= rprior_reg;
            head_slot     <= head_reg;
            last_slot     <= last_reg;
            entry_count   <= count_reg;
            largest_slot  <= max_reg;
            smallest_slot <= min_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* design/sllm_checker.sv */
// ----------------------------------------------------------------------------
// sllm_checker
// Port-level checks on the result channel of the slot linked list manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sllm_checker
    import sllm_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] status,
    input wire logic [7:0] result_slot,
    input wire logic [7:0] head_slot,
    input wire logic [7:0] last_slot,
    input wire logic [7:0] entry_count,
    input wire logic [7:0] largest_slot,
    input wire logic [7:0] smallest_slot
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_slot) && $stable(status))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("undefined status code");

    a_empty_links: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((head_slot == 8'd0) == (entry_count == 8'd0))
                      && ((last_slot == 8'd0) == (entry_count == 8'd0)))
        else $error("head, last and count disagree");

    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_FULL |-> result_slot == 8'd0)
        else $error("full table reported a slot");

    a_empty_extremes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && head_slot == 8'd0 |-> largest_slot == 8'd0 && smallest_slot == 8'd0)
        else $error("extremes set on an empty list");

endmodule

bind slot_linked_list_manager sllm_checker u_sllm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .result_slot   (result_slot),
    .head_slot     (head_slot),
    .last_slot     (last_slot),
    .entry_count   (entry_count),
    .largest_slot  (largest_slot),
    .smallest_slot (smallest_slot)
);

`default_nettype wire

/* test/slot_linked_list_manager_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_linked_list_manager_tb
// Drives list commands through the valid/ready input channel, predicts every
// response with an in-bench slot table model and checks each output beat.
// ----------------------------------------------------------------------------
module slot_linked_list_manager_tb;
    import sllm_pkg::*;

    localparam int NSLOT = 256;
    localparam int N_RANDOM = 500;
    localparam logic [3:0] CMD_UNKNOWN = 4'd12;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  rslot;
        logic [31:0] rval;
        logic [7:0]  rnext;
        logic [7:0]  rprior;
        logic [7:0]  head;
        logic [7:0]  last;
        logic [7:0]  count;
        logic [7:0]  big;
        logic [7:0]  tiny;
    } resp_t;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] val;
        logic [31:0] key;
        logic [7:0]  idx;
        logic        typed;
        logic [1:0]  st;
        logic [7:0]  rs;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  cmd;
    logic [31:0] item_value;
    logic [31:0] order_key;
    logic [7:0]  slot_index;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [7:0]  result_slot;
    logic [31:0] read_value;
    logic [7:0]  read_next;
    logic [7:0]  read_prior;
    logic [7:0]  head_slot;
    logic [7:0]  last_slot;
    logic [7:0]  entry_count;
    logic [7:0]  largest_slot;
    logic [7:0]  smallest_slot;

    // Shadow list table
    logic [7:0]  nxt [NSLOT];
    logic [7:0]  prv [NSLOT];
    logic [31:0] vals [NSLOT];
    logic        used [NSLOT];
    logic [7:0]  n_used;
    logic [7:0]  hi_slot;
    logic [7:0]  lo_slot;

    resp_t expected_resp[$];
    logic  typed_chk[$];
    logic [9:0] typed_val[$];
    int    mismatches;
    bit    sent_all;

    slot_linked_list_manager #(.SLOT_COUNT(NSLOT)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .item_value(item_value), .order_key(order_key),
        .slot_index(slot_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .result_slot(result_slot), .read_value(read_value),
        .read_next(read_next), .read_prior(read_prior), .head_slot(head_slot),
        .last_slot(last_slot), .entry_count(entry_count),
        .largest_slot(largest_slot), .smallest_slot(smallest_slot)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("slot_linked_list_manager_tb: errors");
        $finish;
    end

    function automatic void clear_table();
        for (int i = 0; i < NSLOT; i++)
        begin
            nxt[i] = '0;
            prv[i] = '0;
            vals[i] = '0;
            used[i] = 1'b0;
        end
        vals[0] = ALL_ONES;
        used[0] = 1'b1;
        n_used = '0;
        hi_slot = '0;
        lo_slot = '0;
    endfunction

    // Walk from head; later slot wins ties
    function automatic void rescan_extremes();
        logic [7:0]  s;
        logic [31:0] hv;
        logic [31:0] lv;
        int          k;
        s = nxt[0];
        hv = '0;
        lv = ALL_ONES;
        hi_slot = '0;
        lo_slot = '0;
        k = 0;
        while (s != 0 && k < NSLOT)
        begin
            if (vals[s] >= hv) begin hv = vals[s]; hi_slot = s; end
            if (vals[s] <= lv) begin lv = vals[s]; lo_slot = s; end
            s = nxt[s];
            k++;
        end
    endfunction

    function automatic void link_in(logic [7:0] p, logic [7:0] s, logic [31:0] v);
        logic [7:0] n;
        n = nxt[p];
        nxt[s] = n;
        prv[s] = p;
        nxt[p] = s;
        prv[n] = s;
        vals[s] = v;
        used[s] = 1'b1;
        n_used = n_used + 8'd1;
    endfunction

    function automatic void unlink(logic [7:0] s);
        logic [7:0] p;
        logic [7:0] n;
        p = prv[s];
        n = nxt[s];
        nxt[p] = n;
        prv[n] = p;
        nxt[s] = '0;
        prv[s] = '0;
        vals[s] = '0;
        used[s] = 1'b0;
        n_used = n_used - 8'd1;
    endfunction

    // Apply one command to the shadow table and return the response
    function automatic resp_t apply_list_cmd(logic [3:0] op, logic [31:0] v,
                                             logic [31:0] key, logic [7:0] idx);
        resp_t      r;
        logic [7:0] free_s;
        logic [7:0] tgt;
        logic [7:0] t;
        int         k;
        r = '0;
        if (op <= CMD_ADD_AFTER)
        begin
            if (op == CMD_ADD_AFTER && !used[idx])
            begin
                r.status = STAT_INVALID;
                r.rslot = idx;
            end
            else
            begin
                free_s = '0;
                for (int i = NSLOT - 1; i >= 1; i--)
                    if (!used[i]) free_s = i[7:0];
                if (free_s == 0)
                    r.status = STAT_FULL;
                else
                begin
                    case (op)
                        CMD_ADD_HEAD: tgt = '0;
                        CMD_ADD_TAIL: tgt = prv[0];
                        CMD_ADD_ORDERED:
                        begin
                            t = nxt[0];
                            k = 0;
                            while (t != 0 && key > vals[t] && k < NSLOT)
                            begin
                                t = nxt[t];
                                k++;
                            end
                            tgt = prv[t];
                        end
                        default: tgt = idx;
                    endcase
                    link_in(tgt, free_s, v);
                    rescan_extremes();
                    r.rslot = free_s;
                end
            end
        end
        else if (op <= CMD_REMOVE_TAIL)
        begin
            if (op == CMD_REMOVE_SLOT) tgt = idx;
            else if (op == CMD_REMOVE_HEAD) tgt = nxt[0];
            else tgt = prv[0];
            r.rslot = tgt;
            if (tgt == 0 || !used[tgt])
                r.status = STAT_INVALID;
            else
            begin
                unlink(tgt);
                rescan_extremes();
            end
        end
        else if (op == CMD_SET)
        begin
            r.rslot = idx;
            if (idx == 0 || !used[idx])
                r.status = STAT_INVALID;
            else
            begin
                vals[idx] = v;
                rescan_extremes();
            end
        end
        else if (op == CMD_READ)
        begin
            r.rslot = idx;
            if (!used[idx])
                r.status = STAT_INVALID;
            else
            begin
                r.rval = vals[idx];
                r.rnext = nxt[idx];
                r.rprior = prv[idx];
            end
        end
        else
            r.status = STAT_INVALID;
        r.head = nxt[0];
        r.last = prv[0];
        r.count = n_used;
        r.big = hi_slot;
        r.tiny = lo_slot;
        return r;
    endfunction

    // Send one beat; drop valid for the gap, then hold it until accepted
    task automatic send_beat(logic [3:0] op, logic [31:0] v, logic [31:0] key,
                             logic [7:0] idx, bit typed, logic [1:0] st,
                             logic [7:0] rs);
        int gap;
        gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd <= op;
        item_value <= v;
        order_key <= key;
        slot_index <= idx;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_resp.push_back(apply_list_cmd(op, v, key, idx));
        typed_chk.push_back(typed);
        typed_val.push_back({st, rs});
    endtask

    // Drop valid after the last accepted beat
    task automatic idle_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Random slot index: mostly live slots, sometimes anything
    function automatic logic [7:0] pick_slot();
        logic [7:0] s;
        if ($urandom_range(0, 9) < 7 && n_used != 0)
        begin
            s = nxt[0];
            repeat ($urandom_range(0, n_used - 1)) s = nxt[s];
            return s;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return ALL_ONES;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Stimulus
    initial
    begin
        row_t       rows[$];
        logic [3:0] op;
        int         w;
        in_valid = 1'b0;
        cmd = '0;
        item_value = '0;
        order_key = '0;
        slot_index = '0;
        rst_n = 1'b0;
        sent_all = 1'b0;
        clear_table();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        //            op               value        key          idx typ st         rs
        rows.push_back({CMD_READ,        32'd0,       32'd0,       8'd0, 1'b0, STAT_OK, 8'd0});
        rows.push_back({CMD_REMOVE_HEAD, 32'd0,       32'd0,       8'd0, 1'b1, STAT_INVALID, 8'd0});
        rows.push_back({CMD_REMOVE_TAIL, 32'd0,       32'd0,       8'd0, 1'b1, STAT_INVALID, 8'd0});
        rows.push_back({CMD_ADD_AFTER,   32'd5,       32'd0,       8'd7, 1'b1, STAT_INVALID, 8'd7});
        rows.push_back({CMD_ADD_HEAD,    32'd0,       32'd0,       8'd0, 1'b1, STAT_OK, 8'd1});
        rows.push_back({CMD_ADD_TAIL,    ALL_ONES,    32'd0,       8'd0, 1'b1, STAT_OK, 8'd2});
        rows.push_back({CMD_ADD_ORDERED, 32'd100,     32'd100,     8'd0, 1'b1, STAT_OK, 8'd3});
        rows.push_back({CMD_ADD_ORDERED, 32'd7,       ALL_ONES,    8'd0, 1'b0, STAT_OK, 8'd0});
        rows.push_back({CMD_ADD_ORDERED, 32'd9,       32'd0,       8'd0, 1'b0, STAT_OK, 8'd0});
        rows.push_back({CMD_ADD_AFTER,   32'd100,     32'd0,       8'd0, 1'b0, STAT_OK, 8'd0});
        rows.push_back({CMD_ADD_AFTER,   32'h8000_0000, 32'd0,     8'd2, 1'b0, STAT_OK, 8'd0});
        rows.push_back({CMD_READ,        32'd0,       32'd0,       8'd0, 1'b0, STAT_OK, 8'd0});
        rows.push_back({CMD_READ,        32'd0,       32'd0,       8'd3, 1'b0, STAT_OK, 8'd0});
        rows.push_back({CMD_READ,        32'd0,       32'd0,       8'd255, 1'b1, STAT_INVALID, 8'd255});
        rows.push_back({CMD_SET,         32'd1,       32'd0,       8'd0, 1'b1, STAT_INVALID, 8'd0});
        rows.push_back({CMD_SET,         ALL_ONES,    32'd0,       8'd1, 1'b0, STAT_OK, 8'd0});
        rows.push_back({CMD_SET,         32'd3,       32'd0,       8'd200, 1'b1, STAT_INVALID, 8'd200});
        rows.push_back({CMD_REMOVE_SLOT, 32'd0,       32'd0,       8'd0, 1'b1, STAT_INVALID, 8'd0});
        rows.push_back({CMD_REMOVE_SLOT, 32'd0,       32'd0,       8'd99, 1'b1, STAT_INVALID, 8'd99});
        rows.push_back({CMD_REMOVE_SLOT, 32'd0,       32'd0,       8'd3, 1'b0, STAT_OK, 8'd0});
        rows.push_back({CMD_REMOVE_HEAD, 32'd0,       32'd0,       8'd0, 1'b0, STAT_OK, 8'd0});
        rows.push_back({CMD_REMOVE_TAIL, 32'd0,       32'd0,       8'd0, 1'b0, STAT_OK, 8'd0});
        rows.push_back({CMD_UNKNOWN,     ALL_ONES,    ALL_ONES,    8'd1, 1'b1, STAT_INVALID, 8'd0});
        rows.push_back({4'd15,           32'd0,       32'd0,       8'd0, 1'b1, STAT_INVALID, 8'd0});
        foreach (rows[i])
            send_beat(rows[i].op, rows[i].val, rows[i].key, rows[i].idx,
                      rows[i].typed, rows[i].st, rows[i].rs);

        // Hold off until the pipe drains
        idle_input();
        while (expected_resp.size() != 0) @(negedge clk);

        // Fill the table to force the full case
        while (n_used != 8'd255)
            send_beat($urandom_range(0, 3) == 0 ? CMD_ADD_ORDERED : CMD_ADD_TAIL,
                      pick_value(), pick_value(), 8'd0, 1'b0, STAT_OK, 8'd0);
        send_beat(CMD_ADD_HEAD, 32'd1, 32'd0, 8'd0, 1'b1, STAT_FULL, 8'd0);
        send_beat(CMD_ADD_AFTER, 32'd1, 32'd0, 8'd5, 1'b1, STAT_FULL, 8'd0);
        send_beat(CMD_ADD_AFTER, 32'd1, 32'd0, 8'd0, 1'b1, STAT_FULL, 8'd0);

        // Random traffic, biased toward a mid-sized list
        for (int i = 0; i < N_RANDOM; i++)
        begin
            w = $urandom_range(0, 99);
            if (w < 3)
                op = 4'($urandom_range(9, 15));
            else if (w < 45)
                op = (n_used > 40) ? 4'($urandom_range(4, 6)) : 4'($urandom_range(0, 3));
            else
                op = 4'($urandom_range(0, 8));
            send_beat(op, pick_value(), pick_value(), pick_slot(), 1'b0, STAT_OK, 8'd0);
        end
        idle_input();
        sent_all = 1'b1;
    end

    // Output side: random stall, check every beat
    initial
    begin
        resp_t r;
        resp_t got;
        int    stall;
        int    drain;
        bit    typed;
        logic [9:0] tv;
        out_ready = 1'b0;
        mismatches = 0;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
                out_ready <= 1'b1;
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = {status, result_slot, read_value, read_next, read_prior,
                       head_slot, last_slot, entry_count, largest_slot, smallest_slot};
                if (expected_resp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response beat %h", got);
                end
                else
                begin
                    r = expected_resp.pop_front();
                    typed = typed_chk.pop_front();
                    tv = typed_val.pop_front();
                    // Typed rows also carry a hand value for status and slot
                    if (typed && tv != {r.status, r.rslot})
                        r = '0;
                    if (got != r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h got %h", r, got);
                    end
                end
                stall = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 15);
            end
            if (sent_all && expected_resp.size() == 0)
            begin
                drain = 0;
                while (drain < 40)
                begin
                    @(posedge clk);
                    if (out_valid)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("extra response beat after drain");
                    end
                    drain++;
                end
                if (mismatches == 0)
                    $display("slot_linked_list_manager_tb: clean");
                else
                    $display("slot_linked_list_manager_tb: errors");
                $finish;
            end
        end
    end

endmodule
